### rtl/core/speckle_block_contrast_core_macros.svh
// ----------------------------------------------------------------------------
// speckle block contrast assertion macros
// shared property forms for the core checks
// ----------------------------------------------------------------------------
`ifndef SPECKLE_BLOCK_CONTRAST_CORE_MACROS_SVH
`define SPECKLE_BLOCK_CONTRAST_CORE_MACROS_SVH

// same-cycle implication
`define SBC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("speckle block contrast check failed");

// next-cycle implication
`define SBC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("speckle block contrast check failed");

`endif

### rtl/core/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg
// types, commands and constants shared by the speckle contrast core
// ----------------------------------------------------------------------------
`default_nettype none

package sbc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_BLOCK  = 16;
  localparam int MEM_DEPTH  = MAX_WIDTH;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);

  localparam logic [23:0] K_MAX = 24'h7FFFFF;

  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_BLOCK_SIZE   = 3'd2;
  localparam logic [2:0] REG_CALIB_STILL  = 3'd3;
  localparam logic [2:0] REG_CALIB_MOVING = 3'd4;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] contrast;
    logic [9:0]         block_col;
    logic [9:0]         block_row;
    logic               frame_done;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_RS_LOAD,
    OP_RS_STEP,
    OP_RS_STORE,
    OP_ACCEPT,
    OP_UPDATE,
    OP_MUL,
    OP_DIFF,
    OP_DLOAD,
    OP_DIV_STEP,
    OP_SQ_LOAD,
    OP_SQ_STEP,
    OP_CAL,
    OP_FIN,
    OP_OUT_LOAD
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic blk_done;
    logic skip_div1;
    logic skip_div2;
  } stat_t;

endpackage

`default_nettype wire

### rtl/core/sbc_ctrl.sv
// ----------------------------------------------------------------------------
// sbc_ctrl
// sequencer for clearing, geometry pass, accumulation and contrast math
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  logic          cfg_write,
  input  sbc_pkg::stat_t stat,
  output sbc_pkg::cmd_t  cmd
);
  import sbc_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RESYNC, ST_RSTORE, ST_UPD, ST_MUL, ST_DIFF, ST_DLOAD,
    ST_DIV1, ST_SQLOAD, ST_SQRT, ST_CAL, ST_DIV2, ST_FIN, ST_OUT
  } st_t;

  localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(MEM_DEPTH - 1);
  localparam logic [ADDR_W-1:0] RS_STEPS   = ADDR_W'(10);
  localparam logic [ADDR_W-1:0] DIV1_STEPS = ADDR_W'(45);
  localparam logic [ADDR_W-1:0] SQ_STEPS   = ADDR_W'(22);
  localparam logic [ADDR_W-1:0] DIV2_STEPS = ADDR_W'(39);

  st_t               state;
  logic [ADDR_W-1:0] cnt;
  logic              pend;
  logic              load_ok;

  assign load_ok  = !out_valid || !out_stall;
  assign in_stall = !(state == ST_IDLE && !pend);

  always_comb begin
    cmd.cnt = cnt;
    case (state)
      ST_CLEAR:  cmd.op = OP_CLEAR;
      ST_IDLE:   cmd.op = pend ? OP_RS_LOAD : (in_valid ? OP_ACCEPT : OP_NONE);
      ST_RESYNC: cmd.op = OP_RS_STEP;
      ST_RSTORE: cmd.op = OP_RS_STORE;
      ST_UPD:    cmd.op = OP_UPDATE;
      ST_MUL:    cmd.op = OP_MUL;
      ST_DIFF:   cmd.op = OP_DIFF;
      ST_DLOAD:  cmd.op = OP_DLOAD;
      ST_DIV1:   cmd.op = OP_DIV_STEP;
      ST_SQLOAD: cmd.op = OP_SQ_LOAD;
      ST_SQRT:   cmd.op = OP_SQ_STEP;
      ST_CAL:    cmd.op = OP_CAL;
      ST_DIV2:   cmd.op = OP_DIV_STEP;
      ST_FIN:    cmd.op = OP_FIN;
      ST_OUT:    cmd.op = load_ok ? OP_OUT_LOAD : OP_NONE;
      default:   cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      pend      <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      pend <= cfg_write || (pend && state != ST_IDLE);
      if (state == ST_OUT && load_ok) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == CLEAR_LAST) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (pend) begin
            cnt   <= RS_STEPS;
            state <= ST_RESYNC;
          end else if (in_valid) begin
            state <= ST_UPD;
          end
        end
        ST_RESYNC: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) state <= ST_RSTORE;
        end
        ST_RSTORE: state <= ST_IDLE;
        ST_UPD:    state <= stat.blk_done ? ST_MUL : ST_IDLE;
        ST_MUL:    state <= ST_DIFF;
        ST_DIFF:   state <= ST_DLOAD;
        ST_DLOAD: begin
          cnt   <= DIV1_STEPS;
          state <= stat.skip_div1 ? ST_CAL : ST_DIV1;
        end
        ST_DIV1: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) state <= ST_SQLOAD;
        end
        ST_SQLOAD: begin
          cnt   <= SQ_STEPS;
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) state <= ST_CAL;
        end
        ST_CAL: begin
          cnt   <= DIV2_STEPS;
          state <= stat.skip_div2 ? ST_OUT : ST_DIV2;
        end
        ST_DIV2: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) state <= ST_FIN;
        end
        ST_FIN: state <= ST_OUT;
        ST_OUT: begin
          if (load_ok) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/sbc_datapath.sv
// ----------------------------------------------------------------------------
// sbc_datapath
// position tracking, column sum memory, divider, square root and calibration
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_datapath (
  input  logic               clk,
  input  logic               rst,
  input  sbc_pkg::cmd_t      cmd,
  input  sbc_pkg::in_item_t  in_item,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output sbc_pkg::stat_t     stat,
  output sbc_pkg::out_item_t out_item
);
  import sbc_pkg::*;

  // configuration
  logic [10:0] image_width, image_height;
  logic [4:0]  block_size;
  logic [23:0] still_ref, moving_ref;
  logic [10:0] w_c, h_c;
  logic [4:0]  b_c;
  logic [8:0]  n_sq;

  // position
  logic [10:0] pos_x, pos_bx;
  logic [9:0]  pos_y, pos_by;
  logic [3:0]  pos_cib, pos_rib;
  logic [10:0] wq, hq;

  logic [10:0] nx, nbx, ny, ax, abx, ay;
  logic [9:0]  nby, aby;
  logic [3:0]  ncib, nrib, acib, arib;
  logic        n_start, n_done, n_last;

  // geometry divider lanes
  logic [10:0] rs_q [4];
  logic [3:0]  rs_r [4];
  logic [10:0] rs_q_next [4];
  logic [3:0]  rs_r_next [4];

  // item latches
  logic [7:0]        p_l;
  logic [ADDR_W-1:0] idx_l;
  logic              start_l, done_l, last_l;
  logic [9:0]        bx_l, by_l;

  // memory
  logic [63:0]       mem [MEM_DEPTH];
  logic [63:0]       rd;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [63:0]       mem_wd;
  logic [15:0]       pp;
  logic [31:0]       s1n, s2n;

  // contrast math
  logic [31:0] s1r, s2r;
  logic [29:0] s1c;
  logic        s1z_r;
  logic [40:0] a_r, d_r;
  logic [59:0] bsq_r, dv_r, dr_r;
  logic [45:0] dn_r, dq_r;
  logic [60:0] dt;
  logic        dge;
  logic [45:0] sx_r, sres_r, sbit_r, sres_nx;
  logic [46:0] ssum;
  logic        sge;
  logic [23:0] k_r, res_r, kdiff, den;
  logic        neg_r, bypass, eq;
  logic [39:0] q40;

  assign w_c = (image_width == '0) ? 11'd1 :
               (image_width > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : image_width;
  assign h_c = (image_height == '0) ? 11'd1 :
               (image_height > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : image_height;
  assign b_c = (block_size == '0) ? 5'd1 :
               (block_size > 5'(MAX_BLOCK)) ? 5'(MAX_BLOCK) : block_size;
  assign n_sq = {4'd0, b_c} * {4'd0, b_c};

  // position of the incoming pixel
  always_comb begin
    nx   = pos_x;
    nbx  = pos_bx;
    ncib = pos_cib;
    ny   = {1'b0, pos_y};
    nby  = pos_by;
    nrib = pos_rib;
    if (in_item.frame_start) begin
      nx   = '0;
      nbx  = '0;
      ncib = '0;
      ny   = '0;
      nby  = '0;
      nrib = '0;
    end else begin
      if (pos_x >= w_c) begin
        nx   = '0;
        nbx  = '0;
        ncib = '0;
        ny   = {1'b0, pos_y} + 11'd1;
        if ({1'b0, pos_rib} + 5'd1 == b_c) begin
          nrib = '0;
          nby  = pos_by + 10'd1;
        end else begin
          nrib = pos_rib + 4'd1;
        end
      end
      if (ny >= h_c) begin
        ny   = '0;
        nby  = '0;
        nrib = '0;
      end
    end
    ax = nx + 11'd1;
    if ({1'b0, ncib} + 5'd1 == b_c) begin
      acib = '0;
      abx  = nbx + 11'd1;
    end else begin
      acib = ncib + 4'd1;
      abx  = nbx;
    end
    ay   = ny;
    aby  = nby;
    arib = nrib;
    // end of line and end of frame wrap
    if (ax >= w_c) begin
      ax   = '0;
      abx  = '0;
      acib = '0;
      ay   = ny + 11'd1;
      if ({1'b0, nrib} + 5'd1 == b_c) begin
        arib = '0;
        aby  = nby + 10'd1;
      end else begin
        arib = nrib + 4'd1;
      end
      if (ay >= h_c) begin
        ay   = '0;
        aby  = '0;
        arib = '0;
      end
    end
  end

  assign n_start = (ncib == '0) && (nrib == '0);
  assign n_done  = ({1'b0, ncib} == b_c - 5'd1) && ({1'b0, nrib} == b_c - 5'd1);
  assign n_last  = (nbx + 11'd1 == wq) && ({1'b0, nby} + 11'd1 == hq);

  // restoring division lanes for x, y, width and height by the block size
  always_comb begin
    logic [4:0] t;
    logic       ge;
    for (int i = 0; i < 4; i++) begin
      t  = {rs_r[i], rs_q[i][10]};
      ge = (t >= b_c);
      rs_r_next[i] = ge ? 4'(t - b_c) : t[3:0];
      rs_q_next[i] = {rs_q[i][9:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd640;
      image_height <= 11'd480;
      block_size   <= 5'd5;
      still_ref    <= '0;
      moving_ref   <= '0;
      pos_x   <= '0;
      pos_bx  <= '0;
      pos_cib <= '0;
      pos_y   <= '0;
      pos_by  <= '0;
      pos_rib <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  image_width  <= cfg_data[10:0];
          REG_IMAGE_HEIGHT: image_height <= cfg_data[10:0];
          REG_BLOCK_SIZE:   block_size   <= cfg_data[4:0];
          REG_CALIB_STILL:  still_ref    <= cfg_data;
          REG_CALIB_MOVING: moving_ref   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == OP_ACCEPT) begin
        pos_x   <= ax;
        pos_bx  <= abx;
        pos_cib <= acib;
        pos_y   <= ay[9:0];
        pos_by  <= aby;
        pos_rib <= arib;
      end else if (cmd.op == OP_RS_STORE) begin
        pos_bx  <= rs_q[0];
        pos_cib <= rs_r[0];
        pos_by  <= rs_q[1][9:0];
        pos_rib <= rs_r[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_RS_LOAD: begin
        rs_q[0] <= pos_x;
        rs_q[1] <= {1'b0, pos_y};
        rs_q[2] <= w_c;
        rs_q[3] <= h_c;
        for (int i = 0; i < 4; i++) rs_r[i] <= '0;
      end
      OP_RS_STEP: begin
        for (int i = 0; i < 4; i++) begin
          rs_q[i] <= rs_q_next[i];
          rs_r[i] <= rs_r_next[i];
        end
      end
      OP_RS_STORE: begin
        wq <= rs_q[2];
        hq <= rs_q[3];
      end
      default: ;
    endcase
  end

  // column sums
  assign pp  = {8'd0, p_l} * {8'd0, p_l};
  assign s1n = start_l ? {24'd0, p_l} : rd[31:0] + {24'd0, p_l};
  assign s2n = start_l ? {16'd0, pp} : rd[63:32] + {16'd0, pp};

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_l;
    mem_wd = {s2n, s1n};
    case (cmd.op)
      OP_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = cmd.cnt;
        mem_wd = '0;
      end
      OP_UPDATE: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.op == OP_ACCEPT) rd <= mem[nbx[ADDR_W-1:0]];
  end

  // contrast math
  assign s1c  = (s1r > 32'h3FFFFFFF) ? 30'h3FFFFFFF : s1r[29:0];
  assign dt   = {dr_r, dn_r[45]};
  assign dge  = dt >= {1'b0, dv_r};
  assign ssum = {1'b0, sres_r} + {1'b0, sbit_r};
  assign sge  = {1'b0, sx_r} >= ssum;
  assign sres_nx = sge ? (sres_r >> 1) + sbit_r : sres_r >> 1;

  assign bypass = (still_ref == '0) || (moving_ref == '0) || (k_r <= moving_ref);
  assign eq     = (still_ref == moving_ref);
  assign kdiff  = k_r - moving_ref;
  assign den    = (still_ref > moving_ref) ? still_ref - moving_ref
                                           : moving_ref - still_ref;
  assign q40    = dq_r[39:0];

  assign stat.blk_done  = done_l;
  assign stat.skip_div1 = s1z_r || ({33'd0, d_r[40:14]} >= bsq_r);
  assign stat.skip_div2 = bypass || eq;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        p_l     <= in_item.pixel;
        idx_l   <= nbx[ADDR_W-1:0];
        start_l <= n_start;
        done_l  <= n_done;
        last_l  <= n_last;
        bx_l    <= nbx[9:0];
        by_l    <= nby;
      end
      OP_UPDATE: begin
        s1r <= s1n;
        s2r <= s2n;
      end
      OP_MUL: begin
        a_r   <= n_sq * s2r;
        bsq_r <= s1c * s1c;
        s1z_r <= (s1r == '0);
      end
      OP_DIFF: begin
        d_r <= ({19'd0, a_r} > bsq_r) ? 41'({19'd0, a_r} - bsq_r) : '0;
      end
      OP_DLOAD: begin
        dv_r <= bsq_r;
        dr_r <= {33'd0, d_r[40:14]};
        dn_r <= {d_r[13:0], 32'd0};
        dq_r <= '0;
        k_r  <= s1z_r ? '0 : K_MAX;
      end
      OP_DIV_STEP: begin
        dr_r <= dge ? 60'(dt - {1'b0, dv_r}) : dt[59:0];
        dq_r <= {dq_r[44:0], dge};
        dn_r <= {dn_r[44:0], 1'b0};
      end
      OP_SQ_LOAD: begin
        sx_r   <= dq_r;
        sres_r <= '0;
        sbit_r <= 46'd1 << 44;
      end
      OP_SQ_STEP: begin
        if (sge) sx_r <= 46'({1'b0, sx_r} - ssum);
        sres_r <= sres_nx;
        sbit_r <= sbit_r >> 2;
        k_r    <= sres_nx[23:0];
      end
      OP_CAL: begin
        res_r <= bypass ? k_r : K_MAX;
        neg_r <= still_ref < moving_ref;
        dv_r  <= {36'd0, den};
        dr_r  <= '0;
        dq_r  <= '0;
        dn_r  <= {kdiff, 22'd0};
      end
      OP_FIN: begin
        if (!neg_r) begin
          res_r <= (q40 > 40'h7FFFFF) ? K_MAX : q40[23:0];
        end else begin
          res_r <= (q40 >= 40'h800000) ? 24'h800000 : 24'd0 - q40[23:0];
        end
      end
      OP_OUT_LOAD: begin
        out_item.contrast   <= $signed(res_r);
        out_item.block_col  <= bx_l;
        out_item.block_row  <= by_l;
        out_item.frame_done <= last_l;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/speckle_block_contrast_core.sv
// ----------------------------------------------------------------------------
// speckle_block_contrast_core
// spatial speckle contrast of square blocks over a raster grey pixel stream
//
//   channel  dir  handshake          payload
//   in       in   in_valid/in_stall   in_item   (pixel, frame_start)
//   out      out  out_valid/out_stall out_item  (contrast, block_col, row, done)
//   cfg      in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// each pixel is handled by accept, then column memory read-modify-write
// a pixel that closes a block then runs at most the 46-step divider,
// the 23-step square root and the 40-step calibration divider
// after reset a clearing pass of all 1024 memory words and a geometry pass
// hold in_stall high; config writes made before a pass starts add one pass
// a finished item waits in the output register while the next pixels flow
// ----------------------------------------------------------------------------
`default_nettype none
`include "speckle_block_contrast_core_macros.svh"

module speckle_block_contrast_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sbc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output sbc_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import sbc_pkg::*;

  cmd_t cmd;
  stat_t stat;
  logic cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  sbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_write (cfg_write),
    .stat      (stat),
    .cmd       (cmd)
  );

  sbc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .out_item  (out_item)
  );

  `SBC_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `SBC_ASSERT_IMP(a_clear_after_reset, clk, rst, $fell(rst), in_stall)
  `SBC_ASSERT_IMP(a_result_from_work, clk, rst, $rose(out_valid), $past(in_stall))

endmodule

`default_nettype wire

### bench/speckle_block_contrast_checker.sv
// ----------------------------------------------------------------------------
// speckle block contrast checker
// follows register writes and accepted pixels, predicts each block contrast
// and compares every accepted result item with the oldest prediction
// ----------------------------------------------------------------------------
`default_nettype none

module speckle_block_contrast_checker
  import sbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int        errors,
  output int        pending,
  output int        blocks_seen
);

  logic [10:0] width_reg, height_reg;
  logic [4:0]  bsize_reg;
  logic [23:0] still_reg, moving_reg;
  logic [31:0] col_sum [MAX_WIDTH];
  logic [31:0] col_sq  [MAX_WIDTH];
  int unsigned pos_x, pos_y;
  out_item_t   contrast_q[$];

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned res = 0;
    longint unsigned bitv = 64'h4000_0000_0000_0000;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] block_contrast(logic [31:0] s1, logic [31:0] s2,
                                                 int unsigned n);
    longint unsigned a, b, d, q, r;
    if (s1 == 0) return 0;
    if (s1 > 32'h3FFF_FFFF) s1 = 32'h3FFF_FFFF;
    a = longint'(n) * s2;
    b = longint'(s1) * s1;
    d = (a > b) ? a - b : 0;
    q = d / b;
    if (q >= (64'd1 << 14)) return K_MAX;
    r = d % b;
    for (int i = 0; i < 32; i++) begin
      r <<= 1;
      q <<= 1;
      if (r >= b) begin
        r -= b;
        q |= 1;
      end
    end
    q = isqrt(q);
    return (q > K_MAX) ? K_MAX : q[31:0];
  endfunction

  function automatic logic [31:0] calibrated(logic [31:0] k);
    longint unsigned num, q;
    if (still_reg == 0 || moving_reg == 0 || k <= moving_reg) return k;
    num = longint'(k - moving_reg) << 16;
    if (still_reg == moving_reg) return K_MAX;
    if (still_reg > moving_reg) begin
      q = num / (still_reg - moving_reg);
      return (q > K_MAX) ? K_MAX : q[31:0];
    end
    q = num / (moving_reg - still_reg);
    if (q >= 64'd8388608) return 32'h80_0000;
    return (32'h100_0000 - q[31:0]) & 32'hFF_FFFF;
  endfunction

  function automatic void take_pixel(in_item_t it);
    int unsigned w, h, b, bx, by, cx, cy, idx, p;
    logic [31:0] k;
    out_item_t res;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    b = (bsize_reg == 0) ? 1 : (bsize_reg > MAX_BLOCK) ? MAX_BLOCK : bsize_reg;
    p = it.pixel;
    if (it.frame_start) begin
      pos_x = 0;
      pos_y = 0;
    end
    if (pos_x >= w) begin
      pos_x = 0;
      pos_y++;
    end
    if (pos_y >= h) pos_y = 0;
    bx = pos_x / b; cx = pos_x % b;
    by = pos_y / b; cy = pos_y % b;
    idx = (bx < MAX_WIDTH) ? bx : MAX_WIDTH - 1;
    if (cx == 0 && cy == 0) begin
      col_sum[idx] = p;
      col_sq[idx]  = p * p;
    end else begin
      col_sum[idx] += p;
      col_sq[idx]  += p * p;
    end
    pos_x++;
    if (pos_x >= w) begin
      pos_x = 0;
      pos_y++;
      if (pos_y >= h) pos_y = 0;
    end
    if (cx == b - 1 && cy == b - 1) begin
      k = calibrated(block_contrast(col_sum[idx], col_sq[idx], b * b));
      res.contrast   = k[23:0];
      res.block_col  = bx[9:0];
      res.block_row  = by[9:0];
      res.frame_done = (bx == w / b - 1) && (by == h / b - 1);
      contrast_q.push_back(res);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      width_reg  <= 11'd640;
      height_reg <= 11'd480;
      bsize_reg  <= 5'd5;
      still_reg  <= '0;
      moving_reg <= '0;
      pos_x = 0;
      pos_y = 0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        col_sum[i] = 0;
        col_sq[i]  = 0;
      end
      contrast_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_reg  <= cfg_data[10:0];
          REG_IMAGE_HEIGHT: height_reg <= cfg_data[10:0];
          REG_BLOCK_SIZE:   bsize_reg  <= cfg_data[4:0];
          REG_CALIB_STILL:  still_reg  <= cfg_data;
          REG_CALIB_MOVING: moving_reg <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_pixel(in_item);
      if (out_valid && !out_stall) begin
        blocks_seen++;
        if (contrast_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, expected none, actual %h", $time, out_item);
        end else begin
          want = contrast_q.pop_front();
          if (out_item.contrast !== want.contrast) begin
            errors++;
            $display("%0t: contrast expected %h actual %h", $time,
                     want.contrast, out_item.contrast);
          end
          if (out_item.block_col !== want.block_col) begin
            errors++;
            $display("%0t: block_col expected %0d actual %0d", $time,
                     want.block_col, out_item.block_col);
          end
          if (out_item.block_row !== want.block_row) begin
            errors++;
            $display("%0t: block_row expected %0d actual %0d", $time,
                     want.block_row, out_item.block_row);
          end
          if (out_item.frame_done !== want.frame_done) begin
            errors++;
            $display("%0t: frame_done expected %b actual %b", $time,
                     want.frame_done, out_item.frame_done);
          end
        end
      end
    end
    pending = contrast_q.size();
  end

  initial begin
    errors      = 0;
    pending     = 0;
    blocks_seen = 0;
  end

endmodule

`default_nettype wire

### bench/speckle_block_contrast_core_tb.sv
// ----------------------------------------------------------------------------
// speckle_block_contrast_core_tb
// drives pixel frames over many geometries and calibrations with random
// bursts and output stalls; the checker predicts and compares every block
// ----------------------------------------------------------------------------
`default_nettype none

module speckle_block_contrast_core_tb;
  import sbc_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 150;

  // indexes that select no register
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  logic        clk, rst;
  logic        in_valid, in_stall, out_valid, out_stall;
  in_item_t    in_item;
  out_item_t   out_item;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;
  int          errors, pending, blocks_seen;
  int          cycles, pixels_sent, cfg_writes, burst_left, stall_mode;

  speckle_block_contrast_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  speckle_block_contrast_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .blocks_seen(blocks_seen)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stall pattern, mode picked at random among none, light and heavy stalls
  always @(negedge clk) begin
    if (cycles % 300 == 0) stall_mode <= $urandom_range(2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(99) < 30);
      default: out_stall <= ($urandom_range(99) < 80);
    endcase
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic set_geometry(int w, int h, int b, int still, int moving);
    write_reg(REG_IMAGE_WIDTH, 24'(w));
    write_reg(REG_IMAGE_HEIGHT, 24'(h));
    write_reg(REG_BLOCK_SIZE, 24'(b));
    write_reg(REG_CALIB_STILL, 24'(still));
    write_reg(REG_CALIB_MOVING, 24'(moving));
  endtask

  // called at a falling edge
  task automatic push_pixel(logic [7:0] p, logic fs);
    in_valid <= 1'b1;
    in_item  <= '{pixel: p, frame_start: fs};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    pixels_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid   <= 1'b0;
      burst_left = $urandom_range(40);
      repeat ($urandom_range(0, ($urandom_range(3) == 0) ? 12 : 2)) @(negedge clk);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [7:0] pixel_value(int content, int i, int base);
    case (content)
      0: return 8'd0;
      1: return 8'd255;
      2: return (i % 2) ? 8'd255 : 8'd0;
      3: return 8'(base + $urandom_range(4));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_frame(int npix, int content, bit noise);
    int base;
    base = $urandom_range(250);
    for (int i = 0; i < npix; i++)
      push_pixel(pixel_value(content, i, base),
                 (i == 0) || (noise && $urandom_range(40) == 0));
  endtask

  initial begin
    int w, h, b, still, moving;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycles = 0;
    pixels_sent = 0;
    cfg_writes = 0;
    burst_left = 0;
    stall_mode = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset geometry, a few pixels, then a change in mid frame
    @(negedge clk);
    for (int i = 0; i < 10; i++) push_pixel(8'($urandom), i == 0);
    settle();
    set_geometry(2, 2, 1, 0, 0);
    for (int i = 0; i < 4; i++) push_pixel((i == 1 || i == 2) ? 8'd255 : 8'd0, 1'b0);
    settle();
    set_geometry(4, 2, 2, 0, 0);
    send_frame(8, 2, 0);
    send_frame(8, 1, 0);
    settle();
    // register values past the clamps
    set_geometry(0, 0, 0, 0, 0);
    send_frame(3, 4, 0);
    settle();
    set_geometry(16, 16, 31, 24'hFFFFFF, 24'h1);
    send_frame(256, 2, 0);
    settle();
    set_geometry(2047, 1, 1, 0, 0);
    write_reg(REG_SPARE_HI, 24'hAAAAAA);
    write_reg(REG_SPARE_LO, 24'h555555);
    send_frame(40, 4, 0);
    settle();
    set_geometry(1, 2047, 1, 0, 0);
    send_frame(40, 4, 0);
    settle();

    while (pixels_sent < 560) begin
      b = ($urandom_range(5) == 0) ? $urandom_range(16) : $urandom_range(1, 4);
      w = $urandom_range((b > 0) ? b : 1, 20);
      h = $urandom_range((b > 0) ? b : 1, 16);
      if (w * h > 120) h = 120 / w;
      case ($urandom_range(4))
        0: begin still = 0; moving = $urandom_range(40000); end
        1: begin moving = $urandom_range(1, 30000); still = moving + $urandom_range(1, 60000); end
        2: begin moving = $urandom_range(1, 30000); still = $urandom_range(moving); end
        3: begin moving = $urandom_range(1, 30000); still = moving; end
        default: begin still = $urandom & 24'hFFFFFF; moving = $urandom & 24'hFFFFFF; end
      endcase
      set_geometry(w, h, b, still, moving);
      repeat ($urandom_range(1, 3)) begin
        send_frame(w * h, $urandom_range(4) == 4 ? 4 : $urandom_range(4),
                   $urandom_range(4) == 0);
        if ($urandom_range(3) == 0) settle();
      end
      settle();
    end

    settle();
    $display("pixels sent %0d, blocks checked %0d, register writes %0d",
             pixels_sent, blocks_seen, cfg_writes);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
+incdir+rtl/core
rtl/core/sbc_pkg.sv
rtl/core/sbc_ctrl.sv
rtl/core/sbc_datapath.sv
rtl/core/speckle_block_contrast_core.sv
bench/speckle_block_contrast_checker.sv
bench/speckle_block_contrast_core_tb.sv
